/* rtl/ple_pkg.sv */
package ple_pkg;

    localparam int unsigned ST_W = 2;

    typedef enum logic [2:0] {
        K_INS_FRONT = 3'd0,
        K_INS_BACK  = 3'd1,
        K_REM_FRONT = 3'd2,
        K_REM_PID   = 3'd3,
        K_FIND_PID  = 3'd4,
        K_OLDEST    = 3'd5
    } t_kind;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [15:0] HOLE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] pid;
        logic [15:0] proc_size;
        logic [15:0] job_length;
        logic [31:0] arrival_time;
        logic        update_hole;
        logic [31:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_pid;
        logic [15:0] out_size;
        logic [15:0] out_job;
        logic [31:0] out_arrival;
        logic [15:0] out_hole;
        logic [4:0]  entry_count;
    } t_out_item;

    // record payload kept in the slot memory
    typedef struct packed {
        logic [15:0] pid;
        logic [15:0] size;
        logic [15:0] job;
        logic [31:0] arrival;
        logic [15:0] hole;
    } t_rec;

endpackage

/* rtl/ple_store.sv */
module ple_store import ple_pkg::*; #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW = 4
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_raddr,
    output t_rec          o_rdata,
    output logic [AW-1:0] o_rlink,
    input  logic          i_rec_we,
    input  logic [AW-1:0] i_rec_waddr,
    input  t_rec          i_rec_wdata,
    input  logic          i_link_we,
    input  logic [AW-1:0] i_link_waddr,
    input  logic [AW-1:0] i_link_wdata
);

    t_rec        mem_rec  [DEPTH];
    logic [AW-1:0] mem_link [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_rec_we) begin
            mem_rec[i_rec_waddr] <= i_rec_wdata;
        end
        o_rdata <= mem_rec[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            mem_link[i_link_waddr] <= i_link_wdata;
        end
        o_rlink <= mem_link[i_raddr];
    end

endmodule

/* rtl/process_list_engine_unit.sv */
// ordered process table: up to DEPTH records chained through links in a slot memory
// input channel i_in_valid / o_in_stall carries one operation item (t_in_item);
// output channel o_out_valid / i_out_stall returns exactly one result item per
// input item (t_out_item): status, record fields and count after the operation
// inserts and front removal do not walk the list; lookup, removal by pid and
// oldest selection walk the list through the registered memory read port,
// reading each visited entry in state S_READ
// one item is in work at a time; the input stalls while an item is in work or
// while a finished result has not been taken
// a stalled result holds its payload until i_out_stall drops
// reset (i_rst_n low, synchronous) empties the table: count zero, all slots free;
// record memory contents are not cleared and are only read for live entries
module process_list_engine_unit import ple_pkg::*; #(
    parameter int unsigned DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b00000001,
        S_ISSUE   = 8'b00000010,
        S_READ    = 8'b00000100,
        S_HOLE    = 8'b00001000,
        S_HRD     = 8'b00010000,
        S_DONE    = 8'b00100000,
        S_OUT     = 8'b01000000,
        S_ISSUE_W = 8'b10000000
    } t_state;

    t_state        r_state, n_state;
    t_in_item      r_item;
    logic [AW-1:0] r_front, r_back, r_cur, r_prev;
    logic [CW-1:0] r_count, r_pos;
    logic [DEPTH-1:0] r_free;
    logic          r_found;
    logic [31:0]   r_best_wait;
    logic [15:0]   r_best_pid;
    t_rec          r_hit;
    logic [AW-1:0] r_nxt;
    logic          r_has_next;
    t_out_item     r_out;

    logic [AW-1:0] raddr;
    t_rec          rdata;
    logic [AW-1:0] rlink;
    logic          rec_we, link_we;
    logic [AW-1:0] rec_waddr, link_waddr, link_wdata;
    t_rec          rec_wdata;

    ple_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk       (i_clk),
        .i_raddr     (raddr),
        .o_rdata     (rdata),
        .o_rlink     (rlink),
        .i_rec_we    (rec_we),
        .i_rec_waddr (rec_waddr),
        .i_rec_wdata (rec_wdata),
        .i_link_we   (link_we),
        .i_link_waddr(link_waddr),
        .i_link_wdata(link_wdata)
    );

    // lowest free slot
    logic [AW-1:0] free_slot;
    always_comb begin
        free_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (r_free[i]) free_slot = AW'(i);
        end
    end

    logic        full;
    logic [31:0] wait_t;
    logic [15:0] hsum;
    logic [17:0] hsum2;
    assign full   = (r_count == CW'(DEPTH));
    assign wait_t = r_item.now_time - rdata.arrival;
    assign hsum2  = {2'b0, rdata.hole} + {2'b0, r_hit.size} + {2'b0, r_hit.hole};
    assign hsum   = hsum2[17:16] != 2'b0 ? HOLE_MAX : hsum2[15:0];

    t_rec ins_rec;
    always_comb begin
        ins_rec.pid     = r_item.pid;
        ins_rec.size    = r_item.proc_size;
        ins_rec.job     = r_item.job_length;
        ins_rec.arrival = r_item.arrival_time;
        ins_rec.hole    = '0;
    end

    t_out_item n_out;
    logic [AW-1:0] n_front, n_back, n_cur, n_prev, n_nxt;
    logic [CW-1:0] n_count, n_pos;
    logic [DEPTH-1:0] n_free;
    logic        n_found, n_has_next;
    logic [31:0] n_best_wait;
    logic [15:0] n_best_pid;
    t_rec        n_hit;
    t_in_item    n_item;

    function automatic t_out_item mk_out(logic [1:0] st, t_rec r, logic has,
                                         logic [CW-1:0] c);
        t_out_item o;
        o.status      = st;
        o.out_pid     = has ? r.pid : '0;
        o.out_size    = has ? r.size : '0;
        o.out_job     = has ? r.job : '0;
        o.out_arrival = has ? r.arrival : '0;
        o.out_hole    = has ? r.hole : '0;
        o.entry_count = 5'(c);
        return o;
    endfunction

    always_comb begin
        n_state = r_state; n_item = r_item; n_front = r_front; n_back = r_back;
        n_cur = r_cur; n_prev = r_prev; n_count = r_count;
        n_pos = r_pos; n_free = r_free; n_found = r_found;
        n_best_wait = r_best_wait; n_best_pid = r_best_pid; n_hit = r_hit;
        n_nxt = r_nxt; n_has_next = r_has_next; n_out = r_out;
        raddr = r_cur;
        rec_we = 1'b0; rec_waddr = free_slot; rec_wdata = ins_rec;
        link_we = 1'b0; link_waddr = free_slot; link_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_cur = r_front; n_pos = '0; n_found = 1'b0;
                n_best_wait = '0; n_best_pid = '0;
                case (r_item.kind)
                    K_INS_FRONT, K_INS_BACK: begin
                        if (full) begin
                            n_out = mk_out(ST_FULL, ins_rec, 1'b0, r_count);
                            n_state = S_OUT;
                        end else begin
                            rec_we = 1'b1;
                            n_free[free_slot] = 1'b0;
                            link_we = 1'b1;
                            if (r_item.kind == K_INS_FRONT) begin
                                link_wdata = r_front;
                                n_front = free_slot;
                                if (r_count == '0) n_back = free_slot;
                                n_state = S_OUT;
                            end else begin
                                link_wdata = '0;
                                n_back = free_slot;
                                if (r_count == '0) begin
                                    n_front = free_slot;
                                    n_state = S_OUT;
                                end else begin
                                    n_state = S_HOLE; // relink old back next
                                    n_nxt = free_slot;
                                    n_prev = r_back;
                                end
                            end
                            n_count = r_count + 1'b1;
                            n_out = mk_out(ST_OK, ins_rec, 1'b1, r_count + 1'b1);
                        end
                    end
                    K_REM_FRONT, K_REM_PID, K_FIND_PID, K_OLDEST: begin
                        if (r_count == '0) begin
                            n_out = mk_out(ST_NOTFOUND, ins_rec, 1'b0, r_count);
                            n_state = S_OUT;
                        end else begin
                            raddr = r_front;
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        n_out = mk_out(ST_NOTFOUND, ins_rec, 1'b0, r_count);
                        n_state = S_OUT;
                    end
                endcase
            end
            S_READ: begin
                // rdata/rlink belong to slot r_cur
                case (r_item.kind)
                    K_REM_FRONT: begin
                        n_count = r_count - 1'b1;
                        n_free[r_cur] = 1'b1;
                        n_front = rlink;
                        if (r_count == CW'(1)) begin
                            n_front = '0; n_back = '0;
                        end
                        n_out = mk_out(ST_OK, rdata, 1'b1, r_count - 1'b1);
                        n_state = S_OUT;
                    end
                    K_OLDEST: begin
                        if (!wait_t[31] && (!r_found || wait_t > r_best_wait ||
                            (wait_t == r_best_wait && rdata.pid < r_best_pid))) begin
                            n_found = 1'b1;
                            n_best_wait = wait_t; n_best_pid = rdata.pid;
                            n_hit = rdata;
                        end
                        n_pos = r_pos + 1'b1;
                        n_cur = rlink;
                        if (r_pos + 1'b1 == r_count) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_ISSUE_W;
                        end
                    end
                    default: begin
                        if (rdata.pid == r_item.pid) begin
                            n_hit = rdata;
                            n_nxt = rlink;
                            n_has_next = (r_pos + 1'b1) < r_count;
                            n_state = S_DONE;
                            n_found = 1'b1;
                        end else begin
                            n_prev = r_cur;
                            n_cur = rlink;
                            n_pos = r_pos + 1'b1;
                            if (r_pos + 1'b1 == r_count) n_state = S_DONE;
                            else n_state = S_ISSUE_W;
                        end
                    end
                endcase
            end
            S_ISSUE_W: begin
                raddr = r_cur;
                n_state = S_READ;
            end
            S_DONE: begin
                if (!r_found) begin
                    n_out = mk_out(ST_NOTFOUND, r_hit, 1'b0, r_count);
                    n_state = S_OUT;
                end else if (r_item.kind != K_REM_PID) begin
                    n_out = mk_out(ST_OK, r_hit, 1'b1, r_count);
                    n_state = S_OUT;
                end else begin
                    n_count = r_count - 1'b1;
                    n_free[r_cur] = 1'b1;
                    if (r_pos == '0) begin
                        n_front = r_nxt;
                    end else begin
                        link_we = 1'b1; link_waddr = r_prev; link_wdata = r_nxt;
                        if (!r_has_next) n_back = r_prev;
                    end
                    if (r_count == CW'(1)) begin
                        n_front = '0; n_back = '0;
                    end
                    n_out = mk_out(ST_OK, r_hit, 1'b1, r_count - 1'b1);
                    if (r_item.update_hole && r_has_next) begin
                        raddr = r_nxt;
                        n_state = S_HRD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_HRD: begin
                rec_we = 1'b1; rec_waddr = r_nxt;
                rec_wdata = rdata;
                rec_wdata.hole = hsum;
                n_state = S_OUT;
            end
            S_HOLE: begin
                link_we = 1'b1; link_waddr = r_prev; link_wdata = r_nxt;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            r_free  <= '1;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item; r_cur <= n_cur; r_prev <= n_prev;
        r_pos <= n_pos; r_found <= n_found; r_best_wait <= n_best_wait;
        r_best_pid <= n_best_pid; r_hit <= n_hit; r_nxt <= n_nxt;
        r_has_next <= n_has_next; r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_item  = r_out;

endmodule

/* rtl/ple_checker.sv */
module ple_checker import ple_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed under stall");

    // no result is valid in the cycle after an item is accepted
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !o_out_valid)
        else $error("result too early");

    // failure results carry no record
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.out_pid == '0)
        else $error("failed result has record");

    // status code range
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status != 2'd3)
        else $error("bad status");

endmodule

bind process_list_engine_unit ple_checker u_ple_checker (.*);
